// ===== rtl/pee_pkg.sv =====
// Shared constants, widths and types of the progress ETA estimator.
// Used by pee_div, pee_ring and progress_eta_estimator; depends on nothing.
`default_nettype none

package pee_pkg;

  // History and fixed-point format
  localparam int HISTORY_DEPTH   = 64;
  localparam int SLOPE_FRAC_BITS = 32;

  // Field widths
  localparam int PCT_W      = 7;
  localparam int STAMP_W    = 32;
  localparam int SLOPES_W   = 6;
  localparam int SEC_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int SLOPE_W = PCT_W + SLOPE_FRAC_BITS;       // unsigned Q7.F slope
  localparam int RING_AW = $clog2(HISTORY_DEPTH);
  localparam int SCNT_W  = $clog2(HISTORY_DEPTH + 2);     // sample count up to depth+1
  localparam int CNT_W   = SLOPES_W + 1;                  // walk count up to max+1
  localparam int SUM_W   = SLOPE_W + CNT_W;
  localparam int MS_W    = 10;                            // 1000 fits in 10 bits
  localparam int NUM_W   = SUM_W;                         // divider dividend width
  localparam int DEN_W   = SLOPE_W + MS_W;                // divider divisor width
  localparam int DIV_CW  = $clog2(NUM_W + 1);

  // Percentage ceiling
  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  // Slope validity window: 0.00001 to 100 percent per ms
  localparam longint unsigned FIX_ONE       = 64'd1 << SLOPE_FRAC_BITS;
  localparam longint unsigned SLOPE_MIN_VAL = (FIX_ONE + 64'd99999) / 64'd100000;
  localparam longint unsigned SLOPE_MAX_VAL = 64'd100 << SLOPE_FRAC_BITS;
  localparam logic [SLOPE_W-1:0] SLOPE_MIN  = SLOPE_W'(SLOPE_MIN_VAL);
  localparam logic [SLOPE_W-1:0] SLOPE_MAX  = SLOPE_W'(SLOPE_MAX_VAL);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SLOPES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SLOPES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SECONDS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SECONDS = 2'd3;

  // Configuration reset values
  localparam logic [SLOPES_W-1:0] MIN_SLOPES_RST  = SLOPES_W'(4);
  localparam logic [SLOPES_W-1:0] MAX_SLOPES_RST  = SLOPES_W'(10);
  localparam logic [SEC_W-1:0]    MIN_SECONDS_RST = SEC_W'(5);
  localparam logic [SEC_W-1:0]    MAX_SECONDS_RST = SEC_W'(3600);

  // Divider request and response
  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_rsp_t;

  // Slope ring write port
  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] addr;
    logic [SLOPE_W-1:0] data;
  } ring_wr_t;

endpackage

`default_nettype wire

// ===== rtl/pee_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on pee_pkg for widths and the request and response types.
`default_nettype none

module pee_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pee_pkg::div_req_t req,
  output pee_pkg::div_rsp_t      rsp
);

  logic                          busy;
  logic                          done;
  logic [pee_pkg::DIV_CW-1:0]    steps;
  logic [pee_pkg::NUM_W-1:0]     dq;
  logic [pee_pkg::DEN_W-1:0]     rem;
  logic [pee_pkg::DEN_W-1:0]     den_r;
  logic [pee_pkg::DEN_W:0]       trial;
  logic [pee_pkg::DEN_W:0]       diff;
  logic                          take;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dq[pee_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    take  = (trial >= {1'b0, den_r});
  end

  // Sequence control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy  <= 1'b1;
        steps <= pee_pkg::DIV_CW'(pee_pkg::NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == pee_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.go) begin
      dq    <= req.num;
      rem   <= '0;
      den_r <= req.den;
    end else if (busy) begin
      dq  <= {dq[pee_pkg::NUM_W-2:0], take};
      rem <= take ? diff[pee_pkg::DEN_W-1:0] : trial[pee_pkg::DEN_W-1:0];
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = dq;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

// ===== rtl/pee_ring.sv =====
// Slope history memory: one write port, one registered read port.
// Depends on pee_pkg for depth, widths and the write port type.
`default_nettype none

module pee_ring (
  input  wire logic                        clk,
  input  wire pee_pkg::ring_wr_t           wr,
  input  wire logic                        rd_en,
  input  wire logic [pee_pkg::RING_AW-1:0] rd_addr,
  output logic      [pee_pkg::SLOPE_W-1:0] rd_data
);

  logic [pee_pkg::SLOPE_W-1:0] mem [pee_pkg::HISTORY_DEPTH];

  // Store a new slope
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read one slope per cycle while rd_en is high; the registered data follows in the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/progress_eta_estimator.sv =====
// Progress ETA estimator: top level with the sequencer and configuration.
// Depends on pee_pkg, pee_div and pee_ring.
//
// Usage: the input channel (in_valid / in_stall) carries one sample per item:
// progress_pct, stamp_ms and clear_history. The output channel
// (out_valid / out_stall) returns one item per sample: accepted, remaining_s
// and slopes_used. Configuration registers are written through cfg_wr_en,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. One sample is worked at a
// time; in_stall is high from acceptance until the result has moved into
// the output register. A sample takes up to three divisions that hold the
// sequencer on the shared divider (slope, mean, seconds), a walk back
// through the stored slopes at one ring read per cycle, and the states
// idle, store, walk set-up, mean check, scale and done.
// A stalled result holds in the output register; the next sample may be
// accepted meanwhile and finishes only once that register is free.
// Reset (synchronous, active high) empties the history, zeroes the last
// sample and loads the default limits; the ring needs no clearing pass.
`default_nettype none

module progress_eta_estimator (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [pee_pkg::PCT_W-1:0]      progress_pct,
  input  wire logic [pee_pkg::STAMP_W-1:0]    stamp_ms,
  input  wire logic                           clear_history,
  // Output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                accepted,
  output logic      [pee_pkg::SEC_W-1:0]      remaining_s,
  output logic      [pee_pkg::SLOPES_W-1:0]   slopes_used,
  // Configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic [pee_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pee_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SDIV   = 4'd1;
  localparam logic [3:0] S_WRITE  = 4'd2;
  localparam logic [3:0] S_WSTART = 4'd3;
  localparam logic [3:0] S_WALK   = 4'd4;
  localparam logic [3:0] S_MEAN   = 4'd5;
  localparam logic [3:0] S_MDIV   = 4'd6;
  localparam logic [3:0] S_SCALE  = 4'd7;
  localparam logic [3:0] S_QDIV   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // Configuration registers
  logic [pee_pkg::SLOPES_W-1:0] min_slopes;
  logic [pee_pkg::SLOPES_W-1:0] max_slopes;
  logic [pee_pkg::SEC_W-1:0]    min_seconds;
  logic [pee_pkg::SEC_W-1:0]    max_seconds;

  // Sequencer and history state
  logic [3:0]                   state;
  logic [pee_pkg::PCT_W-1:0]    last_pct;
  logic [pee_pkg::STAMP_W-1:0]  last_stamp;
  logic [pee_pkg::SCNT_W-1:0]   sample_count;
  logic [pee_pkg::RING_AW-1:0]  ring_head;
  logic                         acc_r;
  logic [pee_pkg::SLOPE_W-1:0]  slope_r;
  logic [pee_pkg::RING_AW-1:0]  rd_pos;
  logic [pee_pkg::SCNT_W-1:0]   left;
  logic [pee_pkg::SUM_W-1:0]    sum;
  logic [pee_pkg::CNT_W-1:0]    cnt;
  logic                         walk_stop;
  logic                         pend;
  logic [pee_pkg::SLOPE_W-1:0]  mean_r;
  logic [pee_pkg::SEC_W-1:0]    res_rem;
  pee_pkg::div_req_t            div_req;
  pee_pkg::div_rsp_t            div_rsp;
  pee_pkg::ring_wr_t            ring_wr;

  // Combinational helpers
  logic [pee_pkg::PCT_W-1:0]    pct_c;
  logic [pee_pkg::PCT_W-1:0]    lp_eff;
  logic [pee_pkg::STAMP_W-1:0]  ls_eff;
  logic [pee_pkg::SCNT_W-1:0]   sc_eff;
  logic                         acc;
  logic [pee_pkg::PCT_W-1:0]    dy;
  logic [pee_pkg::STAMP_W-1:0]  dt;
  logic                         rd_en;
  logic [pee_pkg::RING_AW-1:0]  rd_addr;
  logic [pee_pkg::SLOPE_W-1:0]  rd_data;
  logic                         hit;
  logic [pee_pkg::CNT_W-1:0]    cnt_inc;
  logic [pee_pkg::DEN_W-1:0]    mean_ext;
  logic [pee_pkg::DEN_W-1:0]    den_ms;
  logic [pee_pkg::PCT_W-1:0]    pct_left;
  logic [pee_pkg::NUM_W-1:0]    min_sec_ext;
  logic [pee_pkg::NUM_W-1:0]    max_sec_ext;
  logic                         q_low;
  logic                         q_high;
  logic                         out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Judge the incoming sample against the (possibly cleared) history
  always_comb begin
    pct_c  = (progress_pct > pee_pkg::PCT_FULL) ? pee_pkg::PCT_FULL : progress_pct;
    lp_eff = clear_history ? '0 : last_pct;
    ls_eff = clear_history ? '0 : last_stamp;
    sc_eff = clear_history ? '0 : sample_count;
    acc    = (pct_c >= lp_eff);
    dy     = pct_c - lp_eff;
    dt     = stamp_ms - ls_eff;
  end

  // Walk back through the ring, one read per cycle
  always_comb begin
    rd_en   = (state == S_WALK) && (left != '0) && !walk_stop;
    rd_addr = (rd_pos == '0) ? pee_pkg::RING_AW'(pee_pkg::HISTORY_DEPTH - 1)
                             : rd_pos - 1'b1;
    hit     = pend && !walk_stop &&
              (rd_data >= pee_pkg::SLOPE_MIN) && (rd_data <= pee_pkg::SLOPE_MAX);
    cnt_inc = cnt + 1'b1;
  end

  // Scale the mean by 1000 as 1024 - 16 - 8; form the percent still to go
  always_comb begin
    mean_ext = pee_pkg::DEN_W'(mean_r);
    den_ms   = (mean_ext << 10) - (mean_ext << 4) - (mean_ext << 3);
    pct_left = pee_pkg::PCT_FULL - last_pct;
  end

  // Range check of the final quotient, exact for the upper bound
  always_comb begin
    min_sec_ext = pee_pkg::NUM_W'(min_seconds);
    max_sec_ext = pee_pkg::NUM_W'(max_seconds);
    q_low       = (div_rsp.quo < min_sec_ext);
    q_high      = (div_rsp.quo > max_sec_ext) ||
                  ((div_rsp.quo == max_sec_ext) && (div_rsp.rem != '0));
  end

  // Ring write of the new slope
  always_comb begin
    ring_wr.we   = (state == S_WRITE);
    ring_wr.addr = ring_head;
    ring_wr.data = slope_r;
  end

  pee_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pee_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_slopes  <= pee_pkg::MIN_SLOPES_RST;
      max_slopes  <= pee_pkg::MAX_SLOPES_RST;
      min_seconds <= pee_pkg::MIN_SECONDS_RST;
      max_seconds <= pee_pkg::MAX_SECONDS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pee_pkg::REG_MIN_SLOPES:  min_slopes  <= cfg_data[pee_pkg::SLOPES_W-1:0];
        pee_pkg::REG_MAX_SLOPES:  max_slopes  <= cfg_data[pee_pkg::SLOPES_W-1:0];
        pee_pkg::REG_MIN_SECONDS: min_seconds <= cfg_data[pee_pkg::SEC_W-1:0];
        pee_pkg::REG_MAX_SECONDS: max_seconds <= cfg_data[pee_pkg::SEC_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: judge, divide for the slope, store, walk, average, estimate
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      last_pct     <= '0;
      last_stamp   <= '0;
      sample_count <= '0;
      ring_head    <= '0;
      walk_stop    <= 1'b0;
      pend         <= 1'b0;
      div_req.go   <= 1'b0;
    end else begin
      div_req.go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            acc_r <= acc;
            if (clear_history) begin
              ring_head <= '0;
            end
            if (acc) begin
              last_pct   <= pct_c;
              last_stamp <= stamp_ms;
              if (sc_eff != pee_pkg::SCNT_W'(pee_pkg::HISTORY_DEPTH + 1)) begin
                sample_count <= sc_eff + 1'b1;
              end else begin
                sample_count <= sc_eff;
              end
            end
            if (acc && (sc_eff != '0)) begin
              if (dt == '0) begin
                slope_r <= '0;
                state   <= S_WRITE;
              end else begin
                div_req.go  <= 1'b1;
                div_req.num <= pee_pkg::NUM_W'({dy, {pee_pkg::SLOPE_FRAC_BITS{1'b0}}});
                div_req.den <= pee_pkg::DEN_W'(dt);
                state       <= S_SDIV;
              end
            end else begin
              state <= S_WSTART;
            end
          end
        end
        S_SDIV: begin
          if (div_rsp.done) begin
            slope_r <= div_rsp.quo[pee_pkg::SLOPE_W-1:0];
            state   <= S_WRITE;
          end
        end
        S_WRITE: begin
          // advance the head past the slope just stored
          if (ring_head == pee_pkg::RING_AW'(pee_pkg::HISTORY_DEPTH - 1)) begin
            ring_head <= '0;
          end else begin
            ring_head <= ring_head + 1'b1;
          end
          state <= S_WSTART;
        end
        S_WSTART: begin
          left      <= (sample_count == '0) ? '0 : sample_count - 1'b1;
          rd_pos    <= ring_head;
          sum       <= '0;
          cnt       <= '0;
          walk_stop <= 1'b0;
          pend      <= 1'b0;
          state     <= S_WALK;
        end
        S_WALK: begin
          pend <= rd_en;
          if (rd_en) begin
            rd_pos <= rd_addr;
            left   <= left - 1'b1;
          end
          if (hit) begin
            sum <= sum + pee_pkg::SUM_W'(rd_data);
            cnt <= cnt_inc;
            if (cnt_inc > pee_pkg::CNT_W'(max_slopes)) begin
              walk_stop <= 1'b1;
            end
          end
          if (walk_stop || ((left == '0) && !pend)) begin
            pend  <= 1'b0;
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          if ((cnt == '0) || (cnt < pee_pkg::CNT_W'(min_slopes))) begin
            res_rem <= '0;
            state   <= S_DONE;
          end else begin
            div_req.go  <= 1'b1;
            div_req.num <= sum;
            div_req.den <= pee_pkg::DEN_W'(cnt);
            state       <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            mean_r <= div_rsp.quo[pee_pkg::SLOPE_W-1:0];
            state  <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (mean_r == '0) begin
            res_rem <= '0;
            state   <= S_DONE;
          end else begin
            div_req.go  <= 1'b1;
            div_req.num <= pee_pkg::NUM_W'({pct_left, {pee_pkg::SLOPE_FRAC_BITS{1'b0}}});
            div_req.den <= den_ms;
            state       <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (div_rsp.done) begin
            res_rem <= (q_low || q_high) ? '0 : div_rsp.quo[pee_pkg::SEC_W-1:0];
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      accepted    <= acc_r;
      remaining_s <= res_rem;
      slopes_used <= (cnt > pee_pkg::CNT_W'({pee_pkg::SLOPES_W{1'b1}}))
                     ? {pee_pkg::SLOPES_W{1'b1}} : cnt[pee_pkg::SLOPES_W-1:0];
    end
  end

  // The divider is never restarted while it is still working
  assert property (@(posedge clk) disable iff (rst) div_req.go |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // A slope is stored only when an earlier sample exists
  assert property (@(posedge clk) disable iff (rst)
    ring_wr.we |-> (sample_count != '0))
    else $error("slope stored without a previous sample");

  // The walk never counts beyond one more than max_slopes
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (cnt <= pee_pkg::CNT_W'(max_slopes) + 1'b1))
    else $error("walk counted past its limit");

  // A non-zero estimate always rests on enough slopes
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (remaining_s != '0)) |-> (slopes_used >= min_slopes))
    else $error("estimate given with too few slopes");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for progress_eta_estimator: drives progress samples,
// predicts each result in place and compares it with what the block returns.
// Depends on pee_pkg and the progress_eta_estimator RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pee_pkg::*;

  typedef struct packed {
    logic [PCT_W-1:0]   pct;
    logic [STAMP_W-1:0] stamp;
    logic               clr;
  } sample_t;

  typedef struct packed {
    logic               acc;
    logic [SEC_W-1:0]   secs;
    logic [SLOPES_W-1:0] used;
  } eta_t;

  typedef struct packed {
    logic [SLOPES_W-1:0] lo_cnt;
    logic [SLOPES_W-1:0] hi_cnt;
    logic [SEC_W-1:0]    lo_sec;
    logic [SEC_W-1:0]    hi_sec;
  } limits_t;

  localparam int RANDOM_SAMPLES = 1950;
  localparam int N_PHASES       = 10;
  localparam int CALM_PHASE     = 3;
  localparam int SQUEEZE_PHASE  = 5;
  localparam int SQUEEZE_CYCLES = 800;
  localparam int TAIL_CYCLES    = 300;
  localparam int REPORT_CAP     = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic [PCT_W-1:0]     progress_pct  = '0;
  logic [STAMP_W-1:0]   stamp_ms      = '0;
  logic                 clear_history = 1'b0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic                 accepted;
  logic [SEC_W-1:0]     remaining_s;
  logic [SLOPES_W-1:0]  slopes_used;
  logic                 cfg_wr_en     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  progress_eta_estimator u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .progress_pct  (progress_pct),
    .stamp_ms      (stamp_ms),
    .clear_history (clear_history),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .remaining_s   (remaining_s),
    .slopes_used   (slopes_used),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Samples waiting to be sent and estimates waiting to come back
  sample_t pending_samples[$];
  eta_t    expected_etas[$];

  // Own copy of the estimator state and limits
  logic [SLOPE_W-1:0]  hist_slope [HISTORY_DEPTH];
  int                  hist_head  = 0;
  int                  hist_fill  = 0;
  logic [PCT_W-1:0]    prev_pct   = '0;
  logic [STAMP_W-1:0]  prev_stamp = '0;
  logic [SLOPES_W-1:0] need_slopes = 6'd4;
  logic [SLOPES_W-1:0] cap_slopes  = 6'd10;
  logic [SEC_W-1:0]    floor_secs  = 16'd5;
  logic [SEC_W-1:0]    ceil_secs   = 16'd3600;

  // Run bookkeeping
  int   errors        = 0;
  int   samples_sent  = 0;
  int   results_seen  = 0;
  int   rejected_seen = 0;
  int   estimates_seen = 0;
  logic item_taken    = 1'b0;
  logic tx_calm       = 1'b0;
  logic rx_calm       = 1'b0;
  logic squeeze       = 1'b0;
  logic squeeze_done  = 1'b0;
  int   hold_left     = 0;

  // Advance the state by one sample and work out the estimate it yields
  task automatic predict_eta(input sample_t smp, output eta_t eta);
    logic [PCT_W-1:0]   pct;
    logic [STAMP_W-1:0] dt;
    longint unsigned    unity, slope, total, mean, num, den, quo, rem;
    int                 avail, used, pos;
    unity = 64'd1 << SLOPE_FRAC_BITS;
    pct = (smp.pct > PCT_W'(100)) ? PCT_W'(100) : smp.pct;
    if (smp.clr) begin
      prev_pct   = '0;
      prev_stamp = '0;
      hist_fill  = 0;
      hist_head  = 0;
    end
    eta = '0;
    // store the slope to the previous sample unless progress went backwards
    if (pct >= prev_pct) begin
      eta.acc = 1'b1;
      if (hist_fill > 0) begin
        dt = smp.stamp - prev_stamp;
        if (dt == '0)
          slope = 64'd0;
        else
          slope = (longint'(int'(pct) - int'(prev_pct)) << SLOPE_FRAC_BITS) / 64'(dt);
        hist_slope[hist_head] = slope[SLOPE_W-1:0];
        hist_head = (hist_head == HISTORY_DEPTH - 1) ? 0 : hist_head + 1;
      end
      if (hist_fill < HISTORY_DEPTH + 1)
        hist_fill++;
      prev_pct   = pct;
      prev_stamp = smp.stamp;
    end
    // walk back from the newest slope, summing the usable ones
    avail = (hist_fill > 0) ? hist_fill - 1 : 0;
    pos   = hist_head;
    total = 0;
    used  = 0;
    for (int k = 0; k < avail; k++) begin
      pos   = (pos == 0) ? HISTORY_DEPTH - 1 : pos - 1;
      slope = hist_slope[pos];
      if (slope * 64'd100000 >= unity && slope <= 64'd100 * unity) begin
        total += slope;
        used++;
        if (used > int'(cap_slopes))
          break;
      end
    end
    // turn the mean slope into seconds left, within the limits
    if (used != 0 && used >= int'(need_slopes)) begin
      mean = total / longint'(used);
      num  = longint'(100 - int'(prev_pct)) << SLOPE_FRAC_BITS;
      den  = mean * 64'd1000;
      if (den != 0) begin
        quo = num / den;
        rem = num % den;
        if (!(quo < floor_secs || quo > ceil_secs || (quo == ceil_secs && rem != 0)))
          eta.secs = quo[SEC_W-1:0];
      end
    end
    eta.used = (used > 63) ? SLOPES_W'(63) : SLOPES_W'(used);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Check results, track limit writes and predict on each accepted sample
  always @(posedge clk) begin : track_proc
    eta_t due;
    eta_t fresh;
    if (!rst) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MIN_SLOPES:  need_slopes = cfg_data[SLOPES_W-1:0];
          REG_MAX_SLOPES:  cap_slopes  = cfg_data[SLOPES_W-1:0];
          REG_MIN_SECONDS: floor_secs  = cfg_data[SEC_W-1:0];
          REG_MAX_SECONDS: ceil_secs   = cfg_data[SEC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_etas.size() == 0) begin
          errors++;
          if (errors <= REPORT_CAP)
            $error("estimate returned with no sample outstanding");
        end else begin
          due = expected_etas.pop_front();
          check_field("accepted", due.acc, accepted);
          check_field("remaining_s", due.secs, remaining_s);
          check_field("slopes_used", due.used, slopes_used);
          results_seen++;
          if (!accepted)
            rejected_seen++;
          if (remaining_s != '0)
            estimates_seen++;
        end
      end
      item_taken = in_valid && !in_stall;
      if (item_taken) begin
        predict_eta(pending_samples[0], fresh);
        expected_etas.push_back(fresh);
        void'(pending_samples.pop_front());
        samples_sent++;
      end
    end
  end

  // Send the next sample, hold it while stalled, idle at random
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      if (pending_samples.size() > 0 && (tx_calm || $urandom_range(99) >= 27)) begin
        in_valid      <= 1'b1;
        progress_pct  <= pending_samples[0].pct;
        stamp_ms      <= pending_samples[0].stamp;
        clear_history <= pending_samples[0].clr;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall results at random, once for a long stretch to fill the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze && !squeeze_done) begin
      squeeze_done <= 1'b1;
      hold_left    <= SQUEEZE_CYCLES;
      out_stall    <= 1'b1;
    end else begin
      out_stall <= !rx_calm && ($urandom_range(99) < 27);
    end
  end

  task automatic push_sample(input int pct, input logic [STAMP_W-1:0] stamp, input logic clr);
    sample_t smp;
    smp.pct   = PCT_W'(pct);
    smp.stamp = stamp;
    smp.clr   = clr;
    pending_samples.push_back(smp);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Queue jobs: rising progress at a per-job pace, with drops and noise mixed in
  task automatic queue_jobs(input int n);
    int               queued, job_left, dy, cur, pace, r;
    logic             fresh_job;
    logic [STAMP_W-1:0] t;
    queued    = 0;
    job_left  = 0;
    cur       = 0;
    pace      = 1000;
    fresh_job = 1'b0;
    t         = $urandom;
    while (queued < n) begin
      if (job_left == 0) begin
        job_left  = ($urandom_range(9) == 0) ? $urandom_range(70, 100) : $urandom_range(4, 40);
        pace      = ($urandom_range(3) == 0) ? $urandom_range(1, 100) : $urandom_range(200, 40000);
        cur       = $urandom_range(0, 20);
        t         = $urandom;
        fresh_job = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 4) begin
        push_sample($urandom_range(0, 127), $urandom, 1'($urandom_range(0, 1)));
      end else if (r < 10 && cur > 0) begin
        // progress falls back below the job's level, mostly rejected by the block
        t = t + $urandom_range(0, pace);
        push_sample(cur - $urandom_range(1, (cur < 10) ? cur : 10), t, 1'b0);
      end else begin
        r  = $urandom_range(9);
        dy = (r == 0) ? 0 : (r < 8) ? 1 : r - 6;
        cur = (cur + dy > 127) ? 127 : cur + dy;
        r = $urandom_range(49);
        if (r == 1)
          t = t + $urandom;
        else if (r > 1)
          t = t + ((dy > 0) ? dy * pace + $urandom_range(0, pace / 4) : $urandom_range(0, pace));
        push_sample(cur, t, fresh_job && ($urandom_range(3) != 0));
        fresh_job = 1'b0;
      end
      queued++;
      job_left--;
    end
  endtask

  // Main sequence
  initial begin : main_proc
    limits_t settings [N_PHASES];
    limits_t lim;
    settings[1] = '{6'd0,  6'd0,  16'd0,     16'd65535};
    settings[2] = '{6'd63, 6'd62, 16'd0,     16'd65535};
    settings[3] = '{6'd1,  6'd62, 16'd0,     16'd65535};
    settings[4] = '{6'd2,  6'd5,  16'd10,    16'd600};
    settings[5] = '{6'd3,  6'd10, 16'd100,   16'd50};
    settings[6] = '{6'd0,  6'd62, 16'd65535, 16'd65535};
    settings[7] = '{6'd4,  6'd10, 16'd5,     16'd3600};
    settings[0] = settings[7];
    for (int i = 8; i < N_PHASES; i++)
      settings[i] = '{SLOPES_W'($urandom_range(0, 8)), SLOPES_W'($urandom_range(0, 62)),
                      SEC_W'($urandom_range(0, 100)), SEC_W'($urandom_range(100, 65535))};
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: clear, clamp, steepest slope, rejection, wrap, flat and tiny slopes
    push_sample(0,   32'd0, 1'b1);
    push_sample(0,   32'd0, 1'b0);
    push_sample(127, 32'd1, 1'b0);
    push_sample(50,  32'd2, 1'b0);
    push_sample(0,   32'hFFFF_FF00, 1'b1);
    push_sample(1,   32'h0000_0100, 1'b0);
    push_sample(2,   32'hFFFF_FFFF, 1'b0);
    // steady job that earns an estimate, then a flat step and a drop
    push_sample(0,   32'd1000, 1'b1);
    for (int i = 1; i <= 5; i++)
      push_sample(2 * i, 32'd1000 + 32'(i) * 32'd20000, 1'b0);
    push_sample(10,  32'd101000, 1'b0);
    push_sample(9,   32'd120000, 1'b0);
    push_sample(100, 32'd200000, 1'b0);
    push_sample(100, 32'd400000, 1'b0);
    push_sample(64,  32'h8000_0000, 1'b1);
    push_sample(65,  32'h8000_0400, 1'b0);
    push_sample(126, 32'h7FFF_FFFF, 1'b0);
    wait (pending_samples.size() == 0 && expected_etas.size() == 0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        lim = settings[ph];
        repeat (4) @(negedge clk);
        set_reg(REG_MIN_SLOPES,  CFG_DATA_W'(lim.lo_cnt));
        set_reg(REG_MAX_SLOPES,  CFG_DATA_W'(lim.hi_cnt));
        set_reg(REG_MIN_SECONDS, lim.lo_sec);
        set_reg(REG_MAX_SECONDS, lim.hi_sec);
      end
      tx_calm = (ph == CALM_PHASE) || (ph == SQUEEZE_PHASE);
      rx_calm = (ph == CALM_PHASE);
      if (ph == SQUEEZE_PHASE)
        squeeze = 1'b1;
      queue_jobs(RANDOM_SAMPLES / N_PHASES);
      wait (pending_samples.size() == 0 && expected_etas.size() == 0);
    end

    // let any stray result show up
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d samples over %0d limit settings, %0d results checked.",
             samples_sent, N_PHASES, results_seen);
    $display("Of these %0d were rejected for falling progress and %0d gave an estimate.",
             rejected_seen, estimates_seen);
    if (errors == 0 && expected_etas.size() == 0)
      $display("progress_eta_estimator regression: pass");
    else
      $display("progress_eta_estimator regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #(30_000_000);
    $display("progress_eta_estimator regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pee_pkg.sv
rtl/pee_div.sv
rtl/pee_ring.sv
rtl/progress_eta_estimator.sv
tb/testbench.sv
